// File: src/tfb_pkg.sv
`default_nettype none

package tfb_pkg;

  // Frame layout
  localparam logic [7:0] FrameHead   = 8'hAA;
  localparam logic [7:0] FrameAddr   = 8'hFF;
  localparam logic [7:0] FrameId     = 8'hF1;
  localparam logic [7:0] FrameLen    = 8'h0C;
  localparam int unsigned FrameBytes = 18;
  localparam int unsigned IdxWidth   = $clog2(FrameBytes);

  // Byte positions inside a frame
  localparam logic [IdxWidth-1:0] IdxHead  = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] IdxAddr  = IdxWidth'(1);
  localparam logic [IdxWidth-1:0] IdxId    = IdxWidth'(2);
  localparam logic [IdxWidth-1:0] IdxLen   = IdxWidth'(3);
  localparam logic [IdxWidth-1:0] IdxALo   = IdxWidth'(4);
  localparam logic [IdxWidth-1:0] IdxAHi   = IdxWidth'(5);
  localparam logic [IdxWidth-1:0] IdxBLo   = IdxWidth'(6);
  localparam logic [IdxWidth-1:0] IdxBHi   = IdxWidth'(7);
  localparam logic [IdxWidth-1:0] IdxCLo   = IdxWidth'(8);
  localparam logic [IdxWidth-1:0] IdxCHi   = IdxWidth'(9);
  localparam logic [IdxWidth-1:0] IdxDLo   = IdxWidth'(10);
  localparam logic [IdxWidth-1:0] IdxDHi   = IdxWidth'(11);
  localparam logic [IdxWidth-1:0] IdxELo   = IdxWidth'(12);
  localparam logic [IdxWidth-1:0] IdxEHi   = IdxWidth'(13);
  localparam logic [IdxWidth-1:0] IdxFLo   = IdxWidth'(14);
  localparam logic [IdxWidth-1:0] IdxFHi   = IdxWidth'(15);
  localparam logic [IdxWidth-1:0] IdxSum   = IdxWidth'(16);
  localparam logic [IdxWidth-1:0] IdxAdd   = IdxWidth'(17);

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic signed [15:0] value_e;
    logic signed [15:0] value_f;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // Pick one of the first sixteen frame bytes
  function automatic logic [7:0] tfb_data_byte(in_item_t item, logic [IdxWidth-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      IdxHead: b = FrameHead;
      IdxAddr: b = FrameAddr;
      IdxId:   b = FrameId;
      IdxLen:  b = FrameLen;
      IdxALo:  b = item.value_a[7:0];
      IdxAHi:  b = item.value_a[15:8];
      IdxBLo:  b = item.value_b[7:0];
      IdxBHi:  b = item.value_b[15:8];
      IdxCLo:  b = item.value_c[7:0];
      IdxCHi:  b = item.value_c[15:8];
      IdxDLo:  b = item.value_d[7:0];
      IdxDHi:  b = item.value_d[15:8];
      IdxELo:  b = item.value_e[7:0];
      IdxEHi:  b = item.value_e[15:8];
      IdxFLo:  b = item.value_f[7:0];
      IdxFHi:  b = item.value_f[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/tfb_queue.sv
`default_nettype none

module tfb_queue
  import tfb_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output      logic     push_ready_o,
  input  wire in_item_t push_data_i,
  output      logic     pop_valid_o,
  input  wire logic     pop_i,
  output      in_item_t pop_data_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  in_item_t            mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming transactions
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/tfb_back.sv
`default_nettype none

module tfb_back
  import tfb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      item_valid_i,
  input  wire in_item_t  item_i,
  output      logic      item_pop_o,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          add_q, add_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic                advance;
  logic [7:0]          data_byte;
  logic [7:0]          sum_base, add_base;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Load a new byte when the output register is free or being drained
  assign advance    = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = advance && (idx_q == IdxAdd);

  assign data_byte = tfb_data_byte(item_i, idx_q);
  assign sum_base  = (idx_q == IdxHead) ? 8'h00 : sum_q;
  assign add_base  = (idx_q == IdxHead) ? 8'h00 : add_q;

  // Select byte, update running checks
  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    add_d       = add_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d      = 1'b1;
      out_d.last_byte  = 1'b0;
      if (idx_q == IdxSum) begin
        out_d.frame_byte = sum_q;
      end else if (idx_q == IdxAdd) begin
        out_d.frame_byte = add_q;
        out_d.last_byte  = 1'b1;
      end else begin
        out_d.frame_byte = data_byte;
        sum_d            = sum_base + data_byte;
        add_d            = add_base + sum_base + data_byte;
      end
      idx_d = (idx_q == IdxAdd) ? IdxHead : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxHead;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload and checks
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    add_q <= add_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// File: src/telemetry_frame_builder_dual_check.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t, six values)
// out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t, byte + last)
//
// Each input transaction yields 18 output transactions, one byte per cycle
// while out_ready_i stays high; the byte serializer is the limit.
// The queue accepts the next transaction while the current frame is still being sent.
// rst_ni clears the queue, the byte counter and the output valid flag.
// A low out_ready_i stalls the serializer; inputs back up only once the queue is full.

`default_nettype none

module telemetry_frame_builder_dual_check
  import tfb_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  logic     q_valid;
  logic     q_pop;
  in_item_t q_data;

  // Front: buffer accepted transactions
  tfb_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_data_i (in_data_i),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  // Back: serialize one frame per transaction
  tfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_data),
    .item_pop_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
